>>> hw/rtl/ppm_p6_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_p6_pkg
// Shared types and constants for the binary PPM stream parser.
// ----------------------------------------------------------------------------
package ppm_p6_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int IMG_W       = 13;
	localparam int IDX_W       = 24;
	localparam int CNT_W       = 25;
	localparam int QDEPTH      = 4;
	localparam int TDATA_W     = 80;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_FIVE = 8'h35;
	localparam logic [7:0] CH_SIX  = 8'h36;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_P    = 8'h50;

	typedef enum logic [2:0] {
		PH_VER,
		PH_WNUM,
		PH_WTAIL,
		PH_HNUM,
		PH_HTAIL,
		PH_MAXV,
		PH_PIX,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		VM_NONE,
		VM_P,
		VM_OLD,
		VM_P6,
		VM_BAD
	} vmatch_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_UNKNOWN,
		ST_UNSUPPORTED,
		ST_BAD_W,
		ST_BAD_H,
		ST_TRUNC,
		ST_SHORT
	} status_t;

	typedef enum logic {
		KIND_PIXEL,
		KIND_STATUS
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [IDX_W-1:0]   pixel_index;
		logic [IMG_W-1:0]   image_width;
		logic [IMG_W-1:0]   image_height;
		status_t            status;
		logic               run_end;
	} result_t;

	typedef struct packed {
		logic pix;
		logic stat;
	} push_t;

endpackage
`default_nettype wire

>>> hw/rtl/ppm_p6_stream_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_top
// Binary PPM (P6) byte stream parser with a small result queue.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one file byte per word in s_tdata, with s_tlast
// set on the final byte of the file. The master channel returns result words:
// m_tuser is 0 for a pixel and 1 for the end-of-file status word, and m_tlast
// marks the last word produced by one input byte.
// Each byte is parsed in the cycle it is accepted; its words are registered
// into the output queue. One byte is taken every clock while the receiver
// keeps up; a byte can produce up to two words, held in a four-word output
// queue.
// s_tready drops while the queue holds more than two words, so a byte that
// brings two words always finds room. A stalled receiver halts input once
// three words are waiting, and no word is lost.
// Reset clears the parser to the start of the version line and empties the
// queue. After the final byte's status word the parser is back at that
// state, ready for the next file.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser_top #(
	parameter int MAX_DIM = ppm_p6_pkg::MAX_DIM_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [7:0]                         s_tdata,  // data_byte
	input  wire logic                               s_tlast,  // end_of_file
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// red, green, blue, pixel_index, image_width, image_height, status, zero pad
	output      logic [ppm_p6_pkg::TDATA_W-1:0]     m_tdata,
	output      logic                               m_tuser,  // kind
	output      logic                               m_tlast   // run_end
);

	localparam int QD    = ppm_p6_pkg::QDEPTH;
	localparam int PTR_W = $clog2(QD);
	localparam int QCW   = $clog2(QD + 1);
	localparam int RW    = $bits(ppm_p6_pkg::result_t) - 2;
	localparam int PAD   = ppm_p6_pkg::TDATA_W - RW;

	logic                  acc, pop;
	ppm_p6_pkg::push_t     push;
	ppm_p6_pkg::result_t   pix_res, stat_res, head;
	ppm_p6_pkg::result_t   q_mem [QD];
	logic [PTR_W-1:0]      wp_q, wp_nx, rp_q;
	logic [QCW-1:0]        cnt_q, push_n;

	assign s_tready = (cnt_q <= QCW'(QD - 2));
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign wp_nx    = wp_q + PTR_W'(1);
	assign push_n   = QCW'(push.pix) + QCW'(push.stat);

	ppm_p6_parse #(
		.MAX_DIM(MAX_DIM)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.data_byte  (s_tdata),
		.end_of_file(s_tlast),
		.push       (push),
		.pix_res    (pix_res),
		.stat_res   (stat_res)
	);

	always_ff @(posedge clk) begin
		if (push.pix) begin
			q_mem[wp_q] <= pix_res;
		end
		if (push.stat) begin
			q_mem[push.pix ? wp_nx : wp_q] <= stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push_n);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + push_n - QCW'(pop);
		end
	end

	assign head    = q_mem[rp_q];
	assign m_tdata = {{PAD{1'b0}}, head.status, head.image_height, head.image_width,
		head.pixel_index, head.blue, head.green, head.red};
	assign m_tuser = head.kind;
	assign m_tlast = head.run_end;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QD))
		else $error("result queue overfilled");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push.pix || push.stat) |-> acc)
		else $error("result produced without an accepted byte");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.stat |-> s_tlast)
		else $error("status word produced for a byte that is not final");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(rp_q)))
		else $error("queue head moved while the receiver stalled");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ppm_p6_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_p6_parse
// Header and pixel parser: updates the frame state for each accepted byte
// and presents the pixel and status words that byte produces.
// ----------------------------------------------------------------------------
module ppm_p6_parse #(
	parameter int MAX_DIM = ppm_p6_pkg::MAX_DIM_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire logic [7:0]          data_byte,
	input  wire logic                end_of_file,
	output ppm_p6_pkg::push_t        push,
	output ppm_p6_pkg::result_t      pix_res,
	output ppm_p6_pkg::result_t      stat_res
);

	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int NW  = DW + 4;
	localparam int PW  = 2 * DW;
	localparam int CW  = (PW > ppm_p6_pkg::CNT_W) ? PW : ppm_p6_pkg::CNT_W;
	localparam int IW  = ppm_p6_pkg::IMG_W;
	localparam int XW  = ppm_p6_pkg::IDX_W;
	localparam int PCW = ppm_p6_pkg::CNT_W;

	ppm_p6_pkg::phase_t  ph_q, ph_d;
	ppm_p6_pkg::vmatch_t vm_q, vm_d;
	ppm_p6_pkg::status_t err_q, err_d;
	logic [DW-1:0]       w_q, w_d, h_q, h_d;
	logic                ds_q, ds_d;
	logic [1:0]          cc_q, cc_d;
	logic [7:0]          r_q, r_d, g_q, g_d;
	logic [PCW-1:0]      pd_q, pd_d, pd_inc;
	logic [CW-1:0]       total_q;
	logic [PW-1:0]       prod;

	logic                is_digit, is_ws, is_term, is_w;
	logic [DW-1:0]       num_val;
	logic [NW-1:0]       num_ext, num_next;
	logic                too_big;
	ppm_p6_pkg::status_t bad_code;

	assign is_digit = (data_byte >= ppm_p6_pkg::CH_ZERO) && (data_byte <= ppm_p6_pkg::CH_NINE);
	assign is_ws    = (data_byte == ppm_p6_pkg::CH_SP) ||
		((data_byte >= ppm_p6_pkg::CH_TAB) && (data_byte <= ppm_p6_pkg::CH_CR));
	assign is_w     = (ph_q == ppm_p6_pkg::PH_WNUM);
	assign is_term  = is_w ? (data_byte == ppm_p6_pkg::CH_SP) : (data_byte == ppm_p6_pkg::CH_LF);
	assign bad_code = is_w ? ppm_p6_pkg::ST_BAD_W : ppm_p6_pkg::ST_BAD_H;
	assign num_val  = is_w ? w_q : h_q;
	assign num_ext  = NW'(num_val);
	assign num_next = (num_ext << 3) + (num_ext << 1) + NW'(data_byte[3:0]);
	assign too_big  = num_next > NW'(MAX_DIM);
	assign pd_inc   = pd_q + PCW'(1);
	assign prod     = PW'(w_q) * PW'(h_q);

	always_comb begin
		ph_d  = ph_q;
		vm_d  = vm_q;
		err_d = err_q;
		w_d   = w_q;
		h_d   = h_q;
		ds_d  = ds_q;
		cc_d  = cc_q;
		r_d   = r_q;
		g_d   = g_q;
		pd_d  = pd_q;
		push  = '0;

		pix_res              = '0;
		pix_res.kind         = ppm_p6_pkg::KIND_PIXEL;
		pix_res.red          = r_q;
		pix_res.green        = g_q;
		pix_res.blue         = data_byte;
		pix_res.pixel_index  = pd_q[XW-1:0];
		pix_res.image_width  = IW'(w_q);
		pix_res.image_height = IW'(h_q);
		pix_res.status       = ppm_p6_pkg::ST_OK;
		pix_res.run_end      = !end_of_file;

		case (ph_q)
			ppm_p6_pkg::PH_VER: begin
				if (data_byte == ppm_p6_pkg::CH_LF) begin
					if (vm_q == ppm_p6_pkg::VM_P6) begin
						ph_d = ppm_p6_pkg::PH_WNUM;
					end else if (vm_q == ppm_p6_pkg::VM_OLD) begin
						err_d = ppm_p6_pkg::ST_UNSUPPORTED;
						ph_d  = ppm_p6_pkg::PH_DONE;
					end else begin
						err_d = ppm_p6_pkg::ST_UNKNOWN;
						ph_d  = ppm_p6_pkg::PH_DONE;
					end
				end else if (vm_q == ppm_p6_pkg::VM_NONE && data_byte == ppm_p6_pkg::CH_P) begin
					vm_d = ppm_p6_pkg::VM_P;
				end else if (vm_q == ppm_p6_pkg::VM_P && data_byte >= ppm_p6_pkg::CH_ONE &&
						data_byte <= ppm_p6_pkg::CH_FIVE) begin
					vm_d = ppm_p6_pkg::VM_OLD;
				end else if (vm_q == ppm_p6_pkg::VM_P && data_byte == ppm_p6_pkg::CH_SIX) begin
					vm_d = ppm_p6_pkg::VM_P6;
				end else begin
					vm_d = ppm_p6_pkg::VM_BAD;
				end
			end
			ppm_p6_pkg::PH_WNUM, ppm_p6_pkg::PH_HNUM: begin
				if (is_digit) begin
					if (too_big) begin
						err_d = bad_code;
						ph_d  = ppm_p6_pkg::PH_DONE;
					end else begin
						if (is_w) begin
							w_d = DW'(num_next);
						end else begin
							h_d = DW'(num_next);
						end
						ds_d = 1'b1;
					end
				end else if (is_term) begin
					if (ds_q) begin
						ds_d = 1'b0;
						ph_d = is_w ? ppm_p6_pkg::PH_HNUM : ppm_p6_pkg::PH_MAXV;
					end else begin
						err_d = bad_code;
						ph_d  = ppm_p6_pkg::PH_DONE;
					end
				end else if (!ds_q) begin
					if (!is_ws) begin
						err_d = bad_code;
						ph_d  = ppm_p6_pkg::PH_DONE;
					end
				end else begin
					ph_d = is_w ? ppm_p6_pkg::PH_WTAIL : ppm_p6_pkg::PH_HTAIL;
				end
			end
			ppm_p6_pkg::PH_WTAIL: begin
				if (data_byte == ppm_p6_pkg::CH_SP) begin
					ds_d = 1'b0;
					ph_d = ppm_p6_pkg::PH_HNUM;
				end
			end
			ppm_p6_pkg::PH_HTAIL: begin
				if (data_byte == ppm_p6_pkg::CH_LF) begin
					ph_d = ppm_p6_pkg::PH_MAXV;
				end
			end
			ppm_p6_pkg::PH_MAXV: begin
				if (data_byte == ppm_p6_pkg::CH_LF) begin
					ph_d = (w_q == '0 || h_q == '0) ? ppm_p6_pkg::PH_DONE : ppm_p6_pkg::PH_PIX;
				end
			end
			ppm_p6_pkg::PH_PIX: begin
				if (cc_q == 2'd0) begin
					r_d  = data_byte;
					cc_d = 2'd1;
				end else if (cc_q == 2'd1) begin
					g_d  = data_byte;
					cc_d = 2'd2;
				end else begin
					push.pix = 1'b1;
					cc_d     = 2'd0;
					pd_d     = pd_inc;
					if (CW'(pd_inc) >= total_q) begin
						ph_d = ppm_p6_pkg::PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase

		stat_res              = '0;
		stat_res.kind         = ppm_p6_pkg::KIND_STATUS;
		stat_res.image_width  = IW'(w_d);
		stat_res.image_height = IW'(h_d);
		stat_res.run_end      = 1'b1;
		if (err_d != ppm_p6_pkg::ST_OK) begin
			stat_res.status = err_d;
		end else if (ph_d == ppm_p6_pkg::PH_DONE) begin
			stat_res.status = ppm_p6_pkg::ST_OK;
		end else if (ph_d == ppm_p6_pkg::PH_PIX) begin
			stat_res.status = ppm_p6_pkg::ST_SHORT;
		end else begin
			stat_res.status = ppm_p6_pkg::ST_TRUNC;
		end

		if (end_of_file) begin
			push.stat = 1'b1;
			ph_d      = ppm_p6_pkg::PH_VER;
			vm_d      = ppm_p6_pkg::VM_NONE;
			err_d     = ppm_p6_pkg::ST_OK;
			w_d       = '0;
			h_d       = '0;
			ds_d      = 1'b0;
			cc_d      = 2'd0;
			r_d       = '0;
			g_d       = '0;
			pd_d      = '0;
		end

		if (!acc) begin
			push = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= ppm_p6_pkg::PH_VER;
			vm_q  <= ppm_p6_pkg::VM_NONE;
			err_q <= ppm_p6_pkg::ST_OK;
			w_q   <= '0;
			h_q   <= '0;
			ds_q  <= 1'b0;
			cc_q  <= 2'd0;
			r_q   <= '0;
			g_q   <= '0;
			pd_q  <= '0;
		end else if (acc) begin
			ph_q  <= ph_d;
			vm_q  <= vm_d;
			err_q <= err_d;
			w_q   <= w_d;
			h_q   <= h_d;
			ds_q  <= ds_d;
			cc_q  <= cc_d;
			r_q   <= r_d;
			g_q   <= g_d;
			pd_q  <= pd_d;
		end
	end

	// The pixel total is captured while the maxval line is skipped, so the
	// compare in the pixel phase never waits on the multiplier.
	always_ff @(posedge clk) begin
		if (ph_q == ppm_p6_pkg::PH_MAXV) begin
			total_q <= CW'(prod);
		end
	end

endmodule
`default_nettype wire
